@@ hw/rtl/sle_pkg.sv @@
// sle_pkg: shared types, field widths, opcodes and status codes
// for the sequential list engine; no dependencies
package sle_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 6;
    localparam int LEN_W    = 7;

    typedef logic [OPCODE_W-1:0]       opcode_t;
    typedef logic [POS_W-1:0]          position_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [FPOS_W-1:0]         fpos_t;
    typedef logic [LEN_W-1:0]          length_t;

    // opcodes
    localparam opcode_t OP_INSERT    = 3'd0;
    localparam opcode_t OP_READ      = 3'd1;
    localparam opcode_t OP_FIND      = 3'd2;
    localparam opcode_t OP_DEL_VALUE = 3'd3;
    localparam opcode_t OP_DEL_POS   = 3'd4;
    localparam opcode_t OP_CLEAR     = 3'd5;

    // result status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_RANGE     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

@@ hw/rtl/sle_if.sv @@
// sle_if: valid/ready channel interfaces for commands and results
// depends on sle_pkg
interface sle_cmd_if;
    import sle_pkg::*;

    logic      valid;
    logic      ready;
    opcode_t   opcode;
    position_t position;
    value_t    value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface sle_res_if;
    import sle_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;
    value_t  read_value;
    fpos_t   found_position;
    length_t list_length;
    logic    is_empty;

    modport source (output valid, output status, output read_value, output found_position,
                    output list_length, output is_empty, input ready);
    modport sink   (input valid, input status, input read_value, input found_position,
                    input list_length, input is_empty, output ready);
endinterface

@@ hw/rtl/sle_ram.sv @@
// sle_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/sequential_list_engine_core.sv @@
// sequential_list_engine_core: array-backed ordered list of signed values
// depends on sle_pkg, sle_if (sle_cmd_if, sle_res_if) and sle_ram
//
//   channel | dir | handshake     | payload
//   cmd     | in  | valid / ready | opcode, position, value
//   res     | out | valid / ready | status, read_value, found_position, list_length, is_empty
//
// one command in flight; a command is decoded, makes its memory walk and is then handed
// to the result register; insert walks from the tail down to its position, delete at
// position from just past it to the tail, find / delete by value scan at most count entries;
// the single read port of the element RAM sets the walk at one entry per cycle
// reset clears the entry count and the result valid flag; the RAM needs no clearing
// a stalled result sits in the output register while the next command is taken
module sequential_list_engine_core #(
    parameter int LIST_DEPTH = 64
) (
    input logic     clk,
    input logic     rst_n,
    sle_cmd_if.sink cmd,
    sle_res_if.source res
);
    import sle_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT_UP = 3'd3;
    localparam logic [2:0] S_PUT      = 3'd4;
    localparam logic [2:0] S_SHIFT_DN = 3'd5;
    localparam logic [2:0] S_TRIM     = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          pend_reg, pend_next;
    logic          chk_reg, chk_next;
    logic          res_valid_reg, res_valid_next;

    // command and result payload
    opcode_t       op_reg, op_next;
    logic [CW-1:0] pos_reg, pos_next;
    value_t        val_reg, val_next;
    logic [AW-1:0] wa_reg, wa_next;
    status_t       status_reg, status_next;
    value_t        rd_reg, rd_next;
    fpos_t         fpos_reg, fpos_next;
    status_t       res_status_reg, res_status_next;
    value_t        res_rd_reg, res_rd_next;
    fpos_t         res_fpos_reg, res_fpos_next;
    length_t       res_len_reg, res_len_next;
    logic          res_empty_reg, res_empty_next;

    // element memory port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    value_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    value_t        ram_rdata;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          out_free;

    sle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_x     = XW'(cmd.position);
    assign cnt_x     = XW'(cnt_reg);
    assign out_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    // sequencer: decode, memory walk and result hand-off
    // shifts read one slot and write the previous read in the next cycle, so a
    // write never targets an entry whose read is still outstanding
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        pend_next       = 1'b0;
        chk_next        = 1'b0;
        op_next         = op_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        wa_next         = wa_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        fpos_next       = fpos_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        res_fpos_next   = res_fpos_reg;
        res_len_next    = res_len_reg;
        res_empty_next  = res_empty_reg;

        ram_raddr = AW'(ptr_reg);
        ram_we    = pend_reg;
        ram_waddr = wa_reg;
        ram_wdata = ram_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = AW'(pos_x);
                if (cmd.valid)
                begin
                    op_next     = cmd.opcode;
                    val_next    = cmd.value;
                    pos_next    = CW'(pos_x);
                    status_next = ST_OK;
                    rd_next     = '0;
                    fpos_next   = '0;
                    state_next  = S_DONE;
                    unique case (cmd.opcode)
                        OP_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (cnt_reg == CW'(LIST_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ptr_next   = cnt_reg;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        OP_FIND, OP_DEL_VALUE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_DEL_POS:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = CW'(pos_x) + CW'(1);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end

            // read data trails the pointer by one entry
            S_SCAN:
            begin
                if (chk_reg && (ram_rdata == val_reg))
                begin
                    if (op_reg == OP_FIND)
                    begin
                        fpos_next  = FPOS_W'(ptr_reg - CW'(1));
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // pointer already sits one past the match
                        state_next = S_SHIFT_DN;
                    end
                end
                else if (ptr_reg == cnt_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    ram_raddr = AW'(ptr_reg);
                    ptr_next  = ptr_reg + CW'(1);
                    chk_next  = 1'b1;
                end
            end

            // move entries up, from the tail down to the insert position
            S_SHIFT_UP:
            begin
                if (ptr_reg > pos_reg)
                begin
                    ram_raddr = AW'(ptr_reg - CW'(1));
                    pend_next = 1'b1;
                    wa_next   = AW'(ptr_reg);
                    ptr_next  = ptr_reg - CW'(1);
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            // drain the last shift write, then store the new value
            S_PUT:
            begin
                if (!pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(pos_reg);
                    ram_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_DONE;
                end
            end

            // move entries down over the removed slot
            S_SHIFT_DN:
            begin
                if (ptr_reg < cnt_reg)
                begin
                    ram_raddr = AW'(ptr_reg);
                    pend_next = 1'b1;
                    wa_next   = AW'(ptr_reg - CW'(1));
                    ptr_next  = ptr_reg + CW'(1);
                end
                else
                begin
                    state_next = S_TRIM;
                end
            end

            S_TRIM:
            begin
                if (!pend_reg)
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_rd_next     = rd_reg;
                    res_fpos_next   = fpos_reg;
                    res_len_next    = LEN_W'(cnt_reg);
                    res_empty_next  = (cnt_reg == '0);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            chk_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            chk_reg       <= chk_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        wa_reg         <= wa_next;
        status_reg     <= status_next;
        rd_reg         <= rd_next;
        fpos_reg       <= fpos_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        res_fpos_reg   <= res_fpos_next;
        res_len_reg    <= res_len_next;
        res_empty_reg  <= res_empty_next;
    end

    // result transaction
    assign res.valid          = res_valid_reg;
    assign res.status         = res_status_reg;
    assign res.read_value     = res_rd_reg;
    assign res.found_position = res_fpos_reg;
    assign res.list_length    = res_len_reg;
    assign res.is_empty       = res_empty_reg;

endmodule

@@ verif/sle_checker.sv @@
`timescale 1ns / 100ps
// sle_checker: watches the command and result channels of the list engine,
// keeps its own copy of the list and compares every result in order
// depends on sle_pkg and sle_if (sle_cmd_if, sle_res_if)
module sle_checker #(
    parameter int LIST_DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    sle_cmd_if   cmd,
    sle_res_if   res,
    output int   mismatches,
    output int   outstanding,
    output int   list_len_now,
    output int   results_seen,
    output int   full_hits,
    output int   rejects
);
    import sle_pkg::*;

    typedef struct packed {
        status_t status;
        value_t  read_value;
        fpos_t   found_position;
        length_t list_length;
        logic    is_empty;
    } list_result_t;

    // shadow copy of the list contents and length
    value_t shelf [LIST_DEPTH];
    int     entries;

    list_result_t predicted_results [$];

    // close the gap left by the entry at position at
    function automatic void drop_entry(input int at);
        for (int k = at; k + 1 < entries; k++)
        begin
            shelf[k] = shelf[k + 1];
        end
        entries--;
    endfunction

    // apply one list operation to the shadow list and build its result
    function automatic list_result_t apply_list_op(input opcode_t op, input position_t pos,
                                                   input value_t val);
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        case (op)
            OP_INSERT:
            begin
                if (int'(pos) > entries)
                    r.status = ST_RANGE;
                else if (entries >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = entries; k > int'(pos); k--)
                    begin
                        shelf[k] = shelf[k - 1];
                    end
                    shelf[pos] = val;
                    entries++;
                end
            end
            OP_READ:
            begin
                if (int'(pos) >= entries)
                    r.status = ST_RANGE;
                else
                    r.read_value = shelf[pos];
            end
            OP_FIND, OP_DEL_VALUE:
            begin
                // first occurrence wins
                for (int k = 0; k < entries; k++)
                begin
                    if (hit < 0 && shelf[k] == val)
                        hit = k;
                end
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else if (op == OP_FIND)
                    r.found_position = fpos_t'(hit);
                else
                    drop_entry(hit);
            end
            OP_DEL_POS:
            begin
                if (int'(pos) >= entries)
                    r.status = ST_RANGE;
                else
                    drop_entry(int'(pos));
            end
            OP_CLEAR:
                entries = 0;
            default:
                ;
        endcase
        r.list_length = length_t'(entries);
        r.is_empty    = (entries == 0);
        return r;
    endfunction

    // one field of a result against its prediction
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // observe both channels at each clock edge
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        list_result_t fresh;
        if (!rst_n)
        begin
            entries      = 0;
            mismatches   = 0;
            results_seen = 0;
            full_hits    = 0;
            rejects      = 0;
            predicted_results.delete();
        end
        else
        begin
            // result transaction: compare with the oldest prediction
            if (res.valid && res.ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got status %0d len %0d",
                             $time, res.status, res.list_length);
                    mismatches++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("status", 32'(want.status), 32'(res.status));
                    check_field("read_value", 32'(want.read_value), 32'(res.read_value));
                    check_field("found_position", 32'(want.found_position),
                                32'(res.found_position));
                    check_field("list_length", 32'(want.list_length), 32'(res.list_length));
                    check_field("is_empty", 32'(want.is_empty), 32'(res.is_empty));
                end
            end
            // command transaction: predict its result
            if (cmd.valid && cmd.ready)
            begin
                fresh = apply_list_op(cmd.opcode, cmd.position, cmd.value);
                if (fresh.status == ST_FULL)
                    full_hits++;
                if (fresh.status == ST_RANGE || fresh.status == ST_NOT_FOUND)
                    rejects++;
                predicted_results.push_back(fresh);
            end
        end
        outstanding  = predicted_results.size();
        list_len_now = entries;
    end

endmodule

@@ verif/tb_sequential_list_engine_core.sv @@
`timescale 1ns / 100ps
// tb_sequential_list_engine_core: stimulus, clock, reset and verdict for the list engine
// depends on sle_pkg, sle_if, sequential_list_engine_core and sle_checker
module tb_sequential_list_engine_core;
    import sle_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam int HOLD_AT    = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int CALM_AT    = 9000;
    localparam int CALM_LEN   = 2000;

    logic clk = 1'b0;
    logic rst_n;

    int mismatches;
    int outstanding;
    int list_len_now;
    int results_seen;
    int full_hits;
    int rejects;
    bit sender_gaps;

    sle_cmd_if cmd_ch ();
    sle_res_if res_ch ();

    sequential_list_engine_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    sle_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .res         (res_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .list_len_now(list_len_now),
        .results_seen(results_seen),
        .full_hits   (full_hits),
        .rejects     (rejects)
    );

    // values that recur often, so finds and deletes hit and duplicates appear
    localparam value_t VALUE_POOL [12] = '{
        32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
        32'sh00000001, 32'sh00000007, 32'sh0000002a, 32'sh55555555,
        32'shaaaaaaaa, 32'sh00001234, 32'shfffffff0, 32'sh40000000
    };

    always #5 clk = ~clk;

    function automatic value_t pick_value();
        if ($urandom_range(0, 99) < 60)
            return VALUE_POOL[$urandom_range(0, 11)];
        return value_t'($urandom);
    endfunction

    // mostly a legal position for the current length, sometimes anywhere
    function automatic position_t pick_position(input int len, input bit allow_end);
        if ($urandom_range(0, 99) >= 85)
            return position_t'($urandom_range(0, 127));
        if (allow_end)
            return position_t'($urandom_range(0, len));
        if (len == 0)
            return '0;
        return position_t'($urandom_range(0, len - 1));
    endfunction

    // offer one command and hold it until the block takes it
    task automatic send_item(input opcode_t op, input position_t pos, input value_t val);
        while (sender_gaps && $urandom_range(0, 99) < 21)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.opcode   <= op;
        cmd_ch.position <= pos;
        cmd_ch.value    <= val;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // random commands with a given balance of inserts and deletes
    task automatic run_phase(input int count, input int insert_pct, input int delete_pct);
        int        roll;
        int        len;
        opcode_t   op;
        position_t pos;
        value_t    val;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            len  = list_len_now;
            val  = pick_value();
            pos  = pick_position(len, 1'b0);
            if (roll < insert_pct)
            begin
                op  = OP_INSERT;
                pos = pick_position(len, 1'b1);
            end
            else if (roll < insert_pct + delete_pct)
                op = $urandom_range(0, 1) ? OP_DEL_VALUE : OP_DEL_POS;
            else if (roll < 97)
                op = $urandom_range(0, 1) ? OP_READ : OP_FIND;
            else if (roll < 99)
                op = OP_CLEAR;
            else
                op = opcode_t'($urandom_range(6, 7));
            send_item(op, pos, val);
        end
    endtask

    // result side: random stalls, one long hold-off and one calm stretch
    initial
    begin
        int cyc;
        cyc = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
                res_ch.ready <= 1'b0;
            else if (cyc >= CALM_AT && cyc < CALM_AT + CALM_LEN)
                res_ch.ready <= 1'b1;
            else
                res_ch.ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("sequential_list_engine_core regression: fail");
        $finish;
    end

    // command side and verdict
    initial
    begin
        sender_gaps     = 1'b1;
        rst_n          <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.opcode   <= OP_CLEAR;
        cmd_ch.position <= '0;
        cmd_ch.value    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, edges of position and value, duplicates, unused opcodes
        send_item(OP_CLEAR, 7'd0, 32'sd0);
        send_item(OP_READ, 7'd0, 32'sd0);
        send_item(OP_DEL_POS, 7'd0, 32'sd0);
        send_item(OP_FIND, 7'd0, 32'sd5);
        send_item(OP_DEL_VALUE, 7'd0, 32'sd5);
        send_item(OP_INSERT, 7'd1, 32'sd9);
        send_item(OP_INSERT, 7'd0, 32'sh7fffffff);
        send_item(OP_INSERT, 7'd1, 32'sh80000000);
        send_item(OP_INSERT, 7'd1, 32'sd0);
        send_item(OP_INSERT, 7'd0, 32'shffffffff);
        send_item(OP_INSERT, 7'd4, 32'sh7fffffff);
        send_item(OP_INSERT, 7'd127, 32'sd3);
        send_item(OP_READ, 7'd0, 32'sd0);
        send_item(OP_READ, 7'd4, 32'sd0);
        send_item(OP_READ, 7'd5, 32'sd0);
        send_item(OP_READ, 7'd127, 32'sd0);
        send_item(OP_FIND, 7'd0, 32'sh7fffffff);
        send_item(OP_FIND, 7'd0, 32'sd12345);
        send_item(OP_DEL_VALUE, 7'd0, 32'sh7fffffff);
        send_item(OP_DEL_VALUE, 7'd0, 32'sd12345);
        send_item(OP_DEL_POS, 7'd3, 32'sd0);
        send_item(OP_DEL_POS, 7'd127, 32'sd0);
        send_item(opcode_t'(6), 7'd0, 32'sd0);
        send_item(opcode_t'(7), 7'd127, 32'shffffffff);
        send_item(OP_CLEAR, 7'd0, 32'sd0);
        send_item(OP_CLEAR, 7'd0, 32'sd0);

        // random: fill to full, churn, drain, refill, churn without gaps, then churn with gaps
        run_phase(150, 85, 5);
        run_phase(150, 40, 35);
        run_phase(150, 10, 70);
        run_phase(150, 80, 10);
        sender_gaps = 1'b0;
        run_phase(100, 45, 35);
        sender_gaps = 1'b1;
        run_phase(50, 45, 35);

        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        // drain, then watch for stray results
        wait (outstanding == 0);
        repeat (LIST_DEPTH + 16) @(posedge clk);

        $display("ran %0d list operations; %0d inserts met a full list, %0d were rejected",
                 results_seen, full_hits, rejects);
        if (mismatches == 0 && outstanding == 0)
            $display("sequential_list_engine_core regression: pass");
        else
            $display("sequential_list_engine_core regression: fail");
        $finish;
    end

endmodule
